// File: rtl/rims_pkg.sv
// shared types and constants for the run insertion merge sorter
`timescale 1ns / 1ps
package rims_pkg;
  localparam int MaxItems  = 64;
  localparam int RunLength = 32;
  localparam int AW = $clog2(MaxItems);
  localparam int CW = $clog2(MaxItems + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INS_RD, ST_INS_CMP, ST_INS_WR,
    ST_MRG_RD, ST_MRG_CMP, ST_CPY_RD, ST_CPY_WR, ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  wr_w;
    addr_t wr_w_addr;
    logic  wr_w_sel_key;   // write key register instead of read data
    logic  wr_w_sel_m;     // write merge-store data
    logic  wr_m;
    addr_t wr_m_addr;
    logic  wr_m_sel_b;     // write the right-hand operand
    addr_t rd_a;
    addr_t rd_b;
    addr_t rd_m;
    logic  ld_key;         // capture work read port a as key
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic a_gt_key;        // work[rd_a] > key
    logic a_gt_b;          // work[rd_a] > work[rd_b]
  } dp_sts_t;
endpackage

// File: rtl/rims_datapath.sv
// work and merge memories with compare logic
`timescale 1ns / 1ps
module rims_datapath (
  input  logic             clk,
  input  logic             in_wr,
  input  rims_pkg::addr_t  in_addr,
  input  rims_pkg::word_t  in_value,
  input  rims_pkg::dp_cmd_t cmd,
  output rims_pkg::dp_sts_t sts,
  output rims_pkg::word_t  rd_a_data
);
  import rims_pkg::*;

  word_t work_mem [MaxItems];
  word_t merge_mem [MaxItems];
  word_t a_r, b_r, m_r, key_r;

  // registered reads
  always_ff @(posedge clk) begin
    a_r <= work_mem[cmd.rd_a];
    b_r <= work_mem[cmd.rd_b];
    m_r <= merge_mem[cmd.rd_m];
  end

  // key capture
  always_ff @(posedge clk) begin
    if (cmd.ld_key) key_r <= a_r;
  end

  // work store write, loading takes priority
  always_ff @(posedge clk) begin
    if (in_wr) work_mem[in_addr] <= in_value;
    else if (cmd.wr_w)
      work_mem[cmd.wr_w_addr] <= cmd.wr_w_sel_key ? key_r :
                                 (cmd.wr_w_sel_m ? m_r : a_r);
  end

  // merge store write
  always_ff @(posedge clk) begin
    if (cmd.wr_m) merge_mem[cmd.wr_m_addr] <= cmd.wr_m_sel_b ? b_r : a_r;
  end

  assign sts.a_gt_key = a_r > key_r;
  assign sts.a_gt_b   = a_r > b_r;
  assign rd_a_data    = a_r;
endmodule

// File: rtl/rims_ctrl.sv
// sequencer for load, insertion, merge passes and output
`timescale 1ns / 1ps
module rims_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_is_last,
  output logic              busy,
  output logic              in_wr,
  output rims_pkg::addr_t   in_addr,
  output rims_pkg::dp_cmd_t cmd,
  input  rims_pkg::dp_sts_t sts,
  output logic              out_valid,
  output logic              out_last_out,
  output logic              out_dropped
);
  import rims_pkg::*;

  localparam int XW = CW + 1;
  typedef logic [XW-1:0] ext_t;

  state_t state_r, state_nxt;
  cnt_t   n_r, n_nxt;
  logic   ovf_r, ovf_nxt;
  // insertion indexes: i outer, j position, lo run start, hi run end
  ext_t   i_r, i_nxt, j_r, j_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  // merge indexes
  ext_t   a_r, a_nxt, b_r, b_nxt, k_r, k_nxt, mid_r, mid_nxt;
  ext_t   w_r, w_nxt;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_LOAD);
  assign in_wr  = accept && (n_r < cnt_t'(MaxItems));
  assign in_addr = addr_t'(n_r);

  // state and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      n_r     <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    a_r <= a_nxt; b_r <= b_nxt; k_r <= k_nxt; mid_r <= mid_nxt; w_r <= w_nxt;
  end

  // helper values for run setup
  ext_t n_x, run_end, m_end, m_mid, seg_lo;
  logic run_left, mrg_done;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; ovf_nxt = ovf_r;
    i_nxt = i_r; j_nxt = j_r; lo_nxt = lo_r; hi_nxt = hi_r;
    a_nxt = a_r; b_nxt = b_r; k_nxt = k_r; mid_nxt = mid_r; w_nxt = w_r;
    cmd = '0;
    out_valid = 1'b0; out_last_out = 1'b0; out_dropped = ovf_r;
    n_x = ext_t'(n_r);
    run_end = '0; m_end = '0; m_mid = '0; seg_lo = '0;
    run_left = 1'b0; mrg_done = 1'b0;
    cmd.rd_a = addr_t'(j_r - 1'b1);
    cmd.rd_b = addr_t'(b_r);
    cmd.rd_m = addr_t'(k_r);

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          n_nxt = in_wr ? n_r + 1'b1 : n_r;
          ovf_nxt = ovf_r | !in_wr;
          if (in_is_last) begin
            lo_nxt = '0;
            hi_nxt = (ext_t'(n_nxt) > ext_t'(RunLength)) ?
                     ext_t'(RunLength - 1) : ext_t'(n_nxt) - 1'b1;
            i_nxt = ext_t'(1);
            j_nxt = ext_t'(1);
            state_nxt = ST_INS_RD;
          end
        end
      end
      // fetch key work[i]
      ST_INS_RD: begin
        if (i_r > hi_r) begin
          // next run or start merging
          seg_lo = lo_r + ext_t'(RunLength);
          if (seg_lo < n_x) begin
            lo_nxt = seg_lo;
            run_end = seg_lo + ext_t'(RunLength - 1);
            hi_nxt = (run_end > n_x - 1'b1) ? n_x - 1'b1 : run_end;
            i_nxt = seg_lo + 1'b1;
            j_nxt = seg_lo + 1'b1;
          end else begin
            w_nxt = ext_t'(RunLength);
            lo_nxt = '0;
            state_nxt = ST_MRG_RD;
          end
        end else begin
          cmd.rd_a = addr_t'(i_r);
          j_nxt = i_r;
          state_nxt = ST_INS_CMP;
        end
      end
      // key loads; then read work[j-1]
      ST_INS_CMP: begin
        if (j_r == i_r) begin
          cmd.ld_key = 1'b1;
        end
        cmd.rd_a = addr_t'(j_r - 1'b1);
        state_nxt = ST_INS_WR;
      end
      ST_INS_WR: begin
        // a_r holds work[j-1]
        cmd.wr_w_addr = addr_t'(j_r);
        if (j_r > lo_r && sts.a_gt_key) begin
          cmd.wr_w = 1'b1;
          j_nxt = j_r - 1'b1;
          state_nxt = ST_INS_CMP;
        end else begin
          cmd.wr_w = 1'b1;
          cmd.wr_w_sel_key = 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = ST_INS_RD;
        end
      end
      // set up a merge segment
      ST_MRG_RD: begin
        if (w_r >= n_x) begin
          k_nxt = '0;
          state_nxt = ST_EMIT;
          cmd.rd_a = '0;
        end else if (lo_r >= n_x) begin
          w_nxt = w_r << 1;
          lo_nxt = '0;
        end else begin
          m_mid = lo_r + w_r - 1'b1;
          m_end = lo_r + (w_r << 1) - 1'b1;
          if (m_mid > n_x - 1'b1) m_mid = n_x - 1'b1;
          if (m_end > n_x - 1'b1) m_end = n_x - 1'b1;
          if (m_mid < m_end) begin
            mid_nxt = m_mid; hi_nxt = m_end;
            a_nxt = lo_r; b_nxt = m_mid + 1'b1; k_nxt = lo_r;
            cmd.rd_a = addr_t'(lo_r);
            cmd.rd_b = addr_t'(m_mid + 1'b1);
            state_nxt = ST_MRG_CMP;
          end else begin
            lo_nxt = lo_r + (w_r << 1);
          end
        end
      end
      // one merged element per cycle: compare and write, next pair read
      ST_MRG_CMP: begin
        cmd.wr_m = 1'b1;
        cmd.wr_m_addr = addr_t'(k_r);
        k_nxt = k_r + 1'b1;
        run_left = (a_r <= mid_r);
        if (run_left && (b_r > hi_r || !sts.a_gt_b)) begin
          a_nxt = a_r + 1'b1;
        end else begin
          cmd.wr_m_sel_b = 1'b1;
          b_nxt = b_r + 1'b1;
        end
        mrg_done = (k_r == hi_r);
        cmd.rd_a = addr_t'(a_nxt);
        cmd.rd_b = addr_t'(b_nxt);
        if (mrg_done) begin
          k_nxt = lo_r;
          state_nxt = ST_CPY_RD;
        end else begin
          state_nxt = ST_MRG_CMP;
        end
      end
      // copy merge store back: read
      ST_CPY_RD: begin
        cmd.rd_m = addr_t'(k_r);
        state_nxt = ST_CPY_WR;
      end
      ST_CPY_WR: begin
        cmd.wr_w = 1'b1;
        cmd.wr_w_sel_m = 1'b1;
        cmd.wr_w_addr = addr_t'(k_r);
        if (k_r == hi_r) begin
          lo_nxt = lo_r + (w_r << 1);
          state_nxt = ST_MRG_RD;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = ST_CPY_RD;
        end
      end
      ST_EMIT: begin
        // a_r holds the registered read of work[k]; use i_r as phase bit
        cmd.rd_a = addr_t'(k_r);
        if (i_r[0]) begin
          out_valid = 1'b1;
          out_last_out = (k_r == n_x - 1'b1);
          i_nxt = '0;
          if (out_last_out) begin
            state_nxt = ST_LOAD;
            n_nxt = '0;
            ovf_nxt = 1'b0;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          i_nxt = ext_t'(1);
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

// File: rtl/run_insertion_merge_sorter.sv
// top level of the run insertion merge sorter
`timescale 1ns / 1ps
// Collects up to 64 signed values, one per cycle while busy is low; the item
// with in_is_last set starts the sort, and busy stays high until the last
// result. Each run of 32 is insertion sorted, then runs are merged bottom-up
// in memory (with a copy back after each merge), and results come out one at
// a time with out_valid high for one cycle each; the receiver cannot stall.
// Extra items are dropped and flagged on out_dropped.
module run_insertion_merge_sorter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rims_pkg::word_t       in_value,
  input  logic                  in_is_last,
  output logic                  out_valid,
  output rims_pkg::word_t       out_sorted_value,
  output logic                  out_last_out,
  output logic                  out_dropped
);
  import rims_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_wr;
  addr_t   in_addr;

  // sequencer
  rims_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_is_last, .busy, .in_wr, .in_addr,
    .cmd, .sts, .out_valid, .out_last_out, .out_dropped
  );

  // memories and compare
  rims_datapath u_dp (
    .clk, .in_wr, .in_addr, .in_value, .cmd, .sts,
    .rd_a_data(out_sorted_value)
  );
endmodule

// File: rtl/rims_checker.sv
// port-level checks for the run insertion merge sorter
`timescale 1ns / 1ps
module rims_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_is_last,
  input logic out_valid,
  input logic out_last_out
);
  // no result while idle
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid) else $error("result while idle");
  // last result ends busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_out |=> !busy) else $error("busy after last");
  // results are never back to back
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");
  // final item makes the block busy
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_is_last |=> busy) else $error("no sort started");
endmodule

bind run_insertion_merge_sorter rims_checker u_rims_checker (
  .clk, .rst_n, .start, .busy, .in_is_last, .out_valid, .out_last_out
);

// File: dv/tb_top.sv
// self-checking testbench for the run insertion merge sorter
`timescale 1ns / 1ps
module tb_top;
  import rims_pkg::*;

  localparam int LimitCycles = 2000000;

  logic clk, rst_n, start, busy, in_is_last;
  word_t in_value;
  logic out_valid, out_last_out, out_dropped;
  word_t out_sorted_value;

  run_insertion_merge_sorter u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_value(in_value), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_sorted_value(out_sorted_value),
    .out_last_out(out_last_out), .out_dropped(out_dropped)
  );

  typedef struct {
    word_t v;
    logic  lst;
    logic  drp;
  } sorted_item_t;

  // predictor state
  word_t        held_values[$];
  logic         held_overflow;
  sorted_item_t sorted_queue[$];

  int n_mismatch, n_checked, n_lists, n_items, n_overflow_lists;
  longint cycles;
  logic idle_ok;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // insertion within runs, then bottom-up merge, stable
  task automatic sort_list(input logic last_flag, input word_t v);
    word_t w[$];
    word_t m[$];
    word_t key;
    int n, j, a, b, lo, mid, hi, wd;
    if (held_values.size() < MaxItems) held_values.push_back(v);
    else held_overflow = 1'b1;
    if (!last_flag) return;
    w = held_values;
    n = w.size();
    for (lo = 0; lo < n; lo += RunLength) begin
      hi = (lo + RunLength - 1 > n - 1) ? n - 1 : lo + RunLength - 1;
      for (int i = lo + 1; i <= hi; i++) begin
        key = w[i];
        j = i;
        while (j > lo && w[j-1] > key) begin
          w[j] = w[j-1];
          j--;
        end
        w[j] = key;
      end
    end
    for (wd = RunLength; wd < n; wd *= 2) begin
      for (lo = 0; lo < n; lo += 2 * wd) begin
        mid = (lo + wd - 1 > n - 1) ? n - 1 : lo + wd - 1;
        hi = (lo + 2 * wd - 1 > n - 1) ? n - 1 : lo + 2 * wd - 1;
        if (mid < hi) begin
          m = {};
          a = lo;
          b = mid + 1;
          while (a <= mid && b <= hi) begin
            if (!(w[a] > w[b])) m.push_back(w[a++]);
            else m.push_back(w[b++]);
          end
          while (a <= mid) m.push_back(w[a++]);
          while (b <= hi) m.push_back(w[b++]);
          for (int k = lo; k <= hi; k++) w[k] = m[k - lo];
        end
      end
    end
    for (int k = 0; k < n; k++)
      sorted_queue.push_back('{w[k], logic'(k == n - 1), held_overflow});
    if (held_overflow) n_overflow_lists++;
    n_lists++;
    held_values = {};
    held_overflow = 1'b0;
  endtask

  task automatic report(input string what, input sorted_item_t exp_r);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch %s: exp v=%0d last=%b drop=%b got v=%0d last=%b drop=%b",
               what, exp_r.v, exp_r.lst, exp_r.drp,
               out_sorted_value, out_last_out, out_dropped);
  endtask

  // result checking
  always @(posedge clk) begin
    sorted_item_t e;
    if (rst_n && out_valid) begin
      if (sorted_queue.size() == 0) begin
        e = '{0, 1'b0, 1'b0};
        report("unexpected result", e);
      end else begin
        e = sorted_queue.pop_front();
        n_checked++;
        if (out_sorted_value !== e.v || out_last_out !== e.lst || out_dropped !== e.drp)
          report("field", e);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one transfer; optional random gap before it
  task automatic send(input word_t v, input logic lst, input sorted_item_t exp_r,
                      input logic has_exp);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    in_is_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sort_list(lst, v);
    n_items++;
    // typed-in expectation for single-item rows
    if (has_exp && lst && sorted_queue.size() > 0) begin
      if (sorted_queue[$].v !== exp_r.v || sorted_queue[$].lst !== exp_r.lst)
        report("directed row", exp_r);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sorted_queue.size() != 0 || busy) @(posedge clk);
  endtask

  typedef struct {
    word_t v;
    logic  lst;
    logic  has_exp;
    word_t exp_v;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
    '{32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
    '{32'sd0,         1'b1, 1'b1, 32'sd0},
    '{32'sh7fff_ffff, 1'b0, 1'b0, 0},
    '{32'sh8000_0000, 1'b0, 1'b0, 0},
    '{-32'sd1,        1'b0, 1'b0, 0},
    '{32'sd1,         1'b0, 1'b0, 0},
    '{32'sd1,         1'b0, 1'b0, 0},
    '{32'sh5555_5555, 1'b0, 1'b0, 0},
    '{32'shaaaa_aaaa, 1'b1, 1'b0, 0}
  };

  initial begin
    int len;
    logic dup;
    sorted_item_t dummy;
    rst_n = 1'b0;
    start = 1'b0;
    in_value = '0;
    in_is_last = 1'b0;
    cycles = 0;
    idle_ok = 1'b1;
    held_overflow = 1'b0;
    n_mismatch = 0; n_checked = 0; n_lists = 0; n_items = 0; n_overflow_lists = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      dummy = '{directed_rows[i].exp_v, 1'b1, 1'b0};
      send(directed_rows[i].v, directed_rows[i].lst, dummy, directed_rows[i].has_exp);
    end
    // full store, then overflow including the final item
    for (int k = 0; k < 66; k++)
      send($urandom, logic'(k == 65), dummy, 1'b0);
    // sender holds off until all results are back
    wait_drained();

    // random lists; short ones mostly, sizes near run and store edges too
    while (n_items < 165) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(30, 34);
        1: len = $urandom_range(62, 68);
        default: len = $urandom_range(1, 12);
      endcase
      if (len > 170 - n_items) len = 170 - n_items;
      dup = ($urandom_range(0, 2) == 0);
      if (n_items > 140) idle_ok = 1'b0;
      for (int k = 0; k < len; k++)
        send(dup ? word_t'($urandom_range(0, 3) - 2) : word_t'($urandom),
             logic'(k == len - 1), dummy, 1'b0);
    end

    wait_drained();
    repeat (200) @(posedge clk);
    $display("%0d items in %0d lists sorted, %0d results checked, %0d lists overflowed",
             n_items, n_lists, n_checked, n_overflow_lists);
    if (n_mismatch == 0 && sorted_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, sorted_queue.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/rims_pkg.sv
rtl/rims_datapath.sv
rtl/rims_ctrl.sv
rtl/run_insertion_merge_sorter.sv
rtl/rims_checker.sv
dv/tb_top.sv
